// File: rtl/core/stramp_pkg.sv
// Shared types and constants for the stepper trapezoid ramp unit.
package stramp_pkg;

  localparam int unsigned POS_W   = 32;
  localparam int unsigned SPEED_W = 27;
  localparam int unsigned ACCEL_W = 30;
  localparam int unsigned TICK_W  = 20;
  localparam int unsigned BRAKE_W = 31;
  localparam int unsigned AMT_W   = 31;
  localparam int unsigned PROD_W  = ACCEL_W + TICK_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // 1000000 = 2^6 * 15625; quotient by 15625 via ceil(2^58 / 15625)
  localparam int unsigned PRE_SHIFT   = 6;
  localparam int unsigned RECIP_W     = 45;
  localparam int unsigned RECIP_SHIFT = 58;
  localparam int unsigned RCHUNK_W    = 15;

  localparam logic [TICK_W-1:0]  US_PER_S    = TICK_W'(1000000);
  localparam logic [TICK_W-1:0]  TICK_RESET  = TICK_W'(1000);
  localparam logic [SPEED_W-1:0] SPEED_MAX   = {SPEED_W{1'b1}};
  localparam logic [RECIP_W-1:0] US_RECIP    = 45'd18446744073710;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_STEP  = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL        = 3'd4;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [POS_W-1:0] start_position;
    logic                    start_forward;
  } in_beat_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic [SPEED_W-1:0]      speed;
    logic                    forward;
    logic                    moving;
  } out_beat_t;

endpackage

// File: rtl/core/stepper_trapezoid_ramp_unit.sv
// Stepper trapezoid ramp unit: per-axis speed ramp, position tracking and step-amount divider.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------
//   in      | sink      | in_valid_i / in_stall_o | in_data_i  (in_beat_t)
//   out     | source    | out_valid_o/ out_stall_i| out_data_o (out_beat_t)
//   cfg     | sink      | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// One beat per cycle while in_stall_o is low; a beat's result is presented in the cycle after
// acceptance unless an earlier result is still held.
// A two-entry output (result register plus skid register) keeps in_stall_o registered.
// A write to accel_rate or tick_period_us recomputes the ramp step: a product state, then a
// reciprocal-multiply state that works through 15-bit slices; in stalls meanwhile.
// Reset is asynchronous, active low; no clearing pass.
module stepper_trapezoid_ramp_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [stramp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [stramp_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  stramp_pkg::in_beat_t                 in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output stramp_pkg::out_beat_t                out_data_o
);
  import stramp_pkg::*;

  typedef enum logic [1:0] {AMT_IDLE, AMT_LOAD, AMT_MUL} amt_state_e;

  localparam int unsigned QN_W   = PROD_W - PRE_SHIFT;
  localparam int unsigned PART_W = QN_W + RCHUNK_W;
  localparam int unsigned ACC_W  = QN_W + RECIP_W;

  // config registers
  logic [ACCEL_W-1:0]      accel_q;
  logic [TICK_W-1:0]       period_q;
  logic [SPEED_W-1:0]      cruise_q;
  logic [BRAKE_W-1:0]      brake_q;
  logic signed [POS_W-1:0] goal_q;

  // step amount unit
  amt_state_e         amt_state_q;
  logic [PROD_W-1:0]  num_q;
  logic [ACC_W-1:0]   acc_q;
  logic [ACC_W-1:0]   acc_nx;
  logic [RCHUNK_W-1:0] rchunk;
  logic [PART_W-1:0]  part;
  logic [AMT_W-1:0]   amt_q;
  logic [1:0]         cnt_q;
  logic               amt_restart;

  // axis state
  logic signed [POS_W-1:0] pos_q, pos_d;
  logic [SPEED_W-1:0]      speed_q, speed_d;
  logic                    fwd_q, fwd_d;
  logic                    run_q, run_d;

  // output stage
  logic      main_valid_q, skid_valid_q;
  out_beat_t main_q, skid_q;
  out_beat_t res;
  logic      in_acc, out_pop;

  assign amt_restart = cfg_we_i &&
                       (cfg_idx_i == REG_ACCEL_RATE || cfg_idx_i == REG_TICK_PERIOD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q  <= '0;
      period_q <= TICK_RESET;
      cruise_q <= '0;
      brake_q  <= '0;
      goal_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ACCEL_RATE:  accel_q  <= cfg_wdata_i[ACCEL_W-1:0];
        REG_TICK_PERIOD: period_q <= cfg_wdata_i[TICK_W-1:0];
        REG_CRUISE:      cruise_q <= cfg_wdata_i[SPEED_W-1:0];
        REG_BRAKE:       brake_q  <= cfg_wdata_i[BRAKE_W-1:0];
        REG_GOAL:        goal_q   <= $signed(cfg_wdata_i[POS_W-1:0]);
        default: ;
      endcase
    end
  end

  // (accel * period) >> 6 times the reciprocal of 15625, one 15-bit slice per cycle
  always_comb begin
    case (cnt_q)
      2'd2:    rchunk = US_RECIP[3*RCHUNK_W-1:2*RCHUNK_W];
      2'd1:    rchunk = US_RECIP[2*RCHUNK_W-1:RCHUNK_W];
      default: rchunk = US_RECIP[RCHUNK_W-1:0];
    endcase
    part   = num_q[PROD_W-1:PRE_SHIFT] * rchunk;
    acc_nx = {acc_q[ACC_W-RCHUNK_W-1:0], {RCHUNK_W{1'b0}}} + ACC_W'(part);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amt_state_q <= AMT_IDLE;
      amt_q       <= '0;
      cnt_q       <= '0;
    end else if (amt_restart) begin
      amt_state_q <= AMT_LOAD;
    end else begin
      unique case (amt_state_q)
        AMT_IDLE: ;
        AMT_LOAD: begin
          cnt_q       <= 2'd2;
          amt_state_q <= AMT_MUL;
        end
        AMT_MUL: begin
          cnt_q <= cnt_q - 2'd1;
          if (cnt_q == 2'd0) begin
            amt_q       <= acc_nx[ACC_W-1:RECIP_SHIFT];
            amt_state_q <= AMT_IDLE;
          end
        end
        default: amt_state_q <= AMT_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (amt_state_q == AMT_LOAD) begin
      num_q <= PROD_W'(accel_q) * PROD_W'(period_q);
      acc_q <= '0;
    end else if (amt_state_q == AMT_MUL) begin
      acc_q <= acc_nx;
    end
  end

  // per-beat update
  logic signed [POS_W:0]   remain;
  logic signed [POS_W+1:0] ahead, spd_s, amt_s, aim_s, nxt_s, brake_s;
  logic [POS_W-1:0]        pos_step;

  always_comb begin
    pos_d   = pos_q;
    speed_d = speed_q;
    fwd_d   = fwd_q;
    run_d   = run_q;
    remain  = $signed({goal_q[POS_W-1], goal_q}) - $signed({pos_q[POS_W-1], pos_q});
    ahead   = fwd_q ? $signed({remain[POS_W], remain}) : -$signed({remain[POS_W], remain});
    spd_s   = $signed({7'd0, speed_q});
    amt_s   = $signed({3'd0, amt_q});
    brake_s = $signed({3'd0, brake_q});
    aim_s   = $signed({7'd0, cruise_q});
    nxt_s   = spd_s;
    pos_step = fwd_q ? (pos_q + 32'd1) : (pos_q - 32'd1);

    case (in_data_i.func)
      FUNC_TICK: begin
        if (run_q) begin
          if (ahead < 0 && spd_s <= amt_s) begin
            fwd_d = !fwd_q;
          end else begin
            if (ahead < 0 || ahead < brake_s) aim_s = '0;
            nxt_s = (aim_s >= spd_s) ? spd_s + amt_s : spd_s - amt_s;
            if (nxt_s >= aim_s - amt_s && nxt_s <= aim_s + amt_s) nxt_s = aim_s;
            if (nxt_s < 0) nxt_s = '0;
            if (nxt_s > $signed({7'd0, SPEED_MAX})) nxt_s = $signed({7'd0, SPEED_MAX});
            speed_d = nxt_s[SPEED_W-1:0];
          end
        end
      end
      FUNC_STEP: begin
        pos_d = $signed(pos_step);
        if (run_q && $signed(pos_step) == goal_q) run_d = 1'b0;
      end
      FUNC_START: begin
        pos_d   = in_data_i.start_position;
        fwd_d   = in_data_i.start_forward;
        speed_d = '0;
        run_d   = in_data_i.start_position != goal_q;
      end
      default: ;
    endcase

    res.position = pos_d;
    res.speed    = speed_d;
    res.forward  = fwd_d;
    res.moving   = run_d;
  end

  assign in_stall_o  = skid_valid_q || (amt_state_q != AMT_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_pop     = main_valid_q && !out_stall_i;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      speed_q <= '0;
      fwd_q   <= 1'b1;
      run_q   <= 1'b0;
    end else if (in_acc) begin
      pos_q   <= pos_d;
      speed_q <= speed_d;
      fwd_q   <= fwd_d;
      run_q   <= run_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (in_acc) begin
      if (main_valid_q && !out_pop) skid_valid_q <= 1'b1;
      else main_valid_q <= 1'b1;
    end else if (out_pop) begin
      if (skid_valid_q) skid_valid_q <= 1'b0;
      else main_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (main_valid_q && !out_pop) skid_q <= res;
      else main_q <= res;
    end else if (out_pop && skid_valid_q) begin
      main_q <= skid_q;
    end
  end

  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q) else $error("skid beat without result beat");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    main_valid_q && out_stall_i |=> main_valid_q) else $error("stalled result dropped");

  a_stall_on_rate_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    amt_restart |=> in_stall_o) else $error("input open while step amount recomputes");

  a_step_keeps_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.func == FUNC_STEP |=> $stable(speed_q))
    else $error("speed changed on step beat");

  a_run_stops_by_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(run_q) |-> $past(in_acc) && $past(in_data_i.func) != FUNC_TICK)
    else $error("motion stopped without step or start");

endmodule
